FILE: rtl/jadq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jadq_pkg
// types, register map and constants for the joystick axis direction qualifier
// ----------------------------------------------------------------------------
package jadq_pkg;

    // axis sample width, fixed by the word layout
    localparam int SAMPLE_BITS = 12;
    // signed width for the filter difference, step and sum
    localparam int DIFF_W = SAMPLE_BITS + 1;
    // signed width for deadzone / threshold compares
    localparam int CMP_W = SAMPLE_BITS + 2;

    localparam int DEF_CAL_SAMPLES = 16;

    localparam logic [SAMPLE_BITS-1:0] MID_LEVEL = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
    localparam logic [SAMPLE_BITS-1:0] CAL_LOW   = SAMPLE_BITS'(50);
    localparam logic [SAMPLE_BITS-1:0] CAL_HIGH  = SAMPLE_BITS'((1 << SAMPLE_BITS) - 51);

    // configuration reset values
    localparam logic [11:0] RST_DEADZONE          = 12'd250;
    localparam logic [11:0] RST_THRESHOLD         = 12'd700;
    localparam logic [15:0] RST_REPEAT_INTERVAL   = 16'd180;
    localparam logic [15:0] RST_DEBOUNCE_INTERVAL = 16'd120;
    localparam logic [2:0]  RST_FILTER_SHIFT      = 3'd2;
    localparam logic        RST_INVERT_AXIS       = 1'b0;

    // apb map
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_DEADZONE          = 3'd0,
        REG_THRESHOLD         = 3'd1,
        REG_REPEAT_INTERVAL   = 3'd2,
        REG_DEBOUNCE_INTERVAL = 3'd3,
        REG_FILTER_SHIFT      = 3'd4,
        REG_INVERT_AXIS       = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        CAL_NONE     = 2'd0,
        CAL_ACCEPTED = 2'd1,
        CAL_REJECTED = 2'd2
    } t_cal_status;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    typedef enum logic {
        ACT_POLL      = 1'b0,
        ACT_CALIBRATE = 1'b1
    } t_action;

    typedef struct packed {
        logic                   action;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   button_pressed;
        logic [31:0]            now_ms;
    } t_in_word;

    typedef struct packed {
        logic        up_event;
        logic        down_event;
        logic        press_event;
        logic [1:0]  calibration_status;
    } t_out_word;

endpackage

FILE: rtl/joystick_axis_direction_qualifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_axis_direction_qualifier_core
// axis filter, deadzone/threshold direction pulses with auto-repeat,
// debounced button and center calibration
// ----------------------------------------------------------------------------
// One input word per clock is taken and one result word comes out for each,
// passing through the input register and then the result register. The
// whole update of a word (low-pass step, offset classification, the two
// 32-bit elapsed-time compares, or the calibration add and mean) sits
// between those two registers, so the block sustains one word per cycle
// under no output stall; a stall on the output holds the result register
// and backs up into the input register and then the input stall.
// Poll words (action 0) move the filtered level by (sample - level) / 2^shift
// truncated toward zero, compare level - center against deadzone and
// threshold, and give an up or down pulse no more often than
// repeat_interval ms; button changes are taken no more often than
// debounce_interval ms, and only a press gives press_event. Calibration
// words (action 1) add up CAL_SAMPLES samples; on the last one a mean
// strictly inside (50, 2^SAMPLE_BITS - 51) loads center and filter level
// (status 1), any other mean is rejected (status 2). The mean is taken by a
// constant reciprocal multiply. Registers sit on the apb port at byte
// address 4*i and must only be written while no word is in flight.
// ----------------------------------------------------------------------------
module joystick_axis_direction_qualifier_core
    import jadq_pkg::*;
#(
    parameter int CAL_SAMPLES = DEF_CAL_SAMPLES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    // input word channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_word           i_in_word,

    // result word channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_word          o_out_word,

    // apb configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // calibration accumulator sizing and reciprocal for the mean
    localparam int CAL_LOG2    = $clog2(CAL_SAMPLES);
    localparam int CAL_CNT_W   = CAL_LOG2;
    localparam int CAL_SUM_W   = SAMPLE_BITS + CAL_LOG2;
    localparam int RECIP_SHIFT = CAL_SUM_W + CAL_LOG2;
    localparam int RECIP_W     = CAL_SUM_W + 2;
    localparam int PROD_W      = CAL_SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] CAL_RECIP =
        RECIP_W'(((2 ** RECIP_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES);
    localparam logic [CAL_CNT_W-1:0] CAL_LAST = CAL_CNT_W'(CAL_SAMPLES - 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [11:0] r_deadzone;
    logic [11:0] r_threshold;
    logic [15:0] r_repeat_interval;
    logic [15:0] r_debounce_interval;
    logic [2:0]  r_filter_shift;
    logic        r_invert_axis;

    logic        w_cfg_wr;
    t_reg_idx    w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone          <= RST_DEADZONE;
            r_threshold         <= RST_THRESHOLD;
            r_repeat_interval   <= RST_REPEAT_INTERVAL;
            r_debounce_interval <= RST_DEBOUNCE_INTERVAL;
            r_filter_shift      <= RST_FILTER_SHIFT;
            r_invert_axis       <= RST_INVERT_AXIS;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_DEADZONE:          r_deadzone          <= pwdata[11:0];
                REG_THRESHOLD:         r_threshold         <= pwdata[11:0];
                REG_REPEAT_INTERVAL:   r_repeat_interval   <= pwdata[15:0];
                REG_DEBOUNCE_INTERVAL: r_debounce_interval <= pwdata[15:0];
                REG_FILTER_SHIFT:      r_filter_shift      <= pwdata[2:0];
                REG_INVERT_AXIS:       r_invert_axis       <= pwdata[0];
                default: ; // unmapped addresses are ignored
            endcase
        end
    end

    // register read-back
    always_comb begin
        prdata = '0;
        case (w_reg_idx)
            REG_DEADZONE:          prdata = PDATA_W'(r_deadzone);
            REG_THRESHOLD:         prdata = PDATA_W'(r_threshold);
            REG_REPEAT_INTERVAL:   prdata = PDATA_W'(r_repeat_interval);
            REG_DEBOUNCE_INTERVAL: prdata = PDATA_W'(r_debounce_interval);
            REG_FILTER_SHIFT:      prdata = PDATA_W'(r_filter_shift);
            REG_INVERT_AXIS:       prdata = PDATA_W'(r_invert_axis);
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake: input register feeds result register
    // ------------------------------------------------------------------
    logic      r_in_vld;
    t_in_word  r_in_word;
    logic      r_out_vld;
    t_out_word r_out_word;
    logic      w_adv;   // word in input register moves to result register
    logic      w_take;  // new word accepted into input register

    assign w_adv       = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !w_adv;
    assign w_take      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // block state
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] r_filtered_level, n_filtered_level;
    logic [SAMPLE_BITS-1:0] r_center_level,   n_center_level;
    logic [31:0]            r_last_dir_time,  n_last_dir_time;
    logic [31:0]            r_last_btn_time,  n_last_btn_time;
    logic                   r_button_state,   n_button_state;
    logic [CAL_SUM_W-1:0]   r_cal_sum,        n_cal_sum;
    logic [CAL_CNT_W-1:0]   r_cal_count,      n_cal_count;
    t_out_word              n_out_word;

    // filter step
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [DIFF_W-1:0] w_bias;
    logic signed [DIFF_W-1:0] w_step;
    logic signed [DIFF_W-1:0] w_filt_sum;
    logic [7:0]               w_bias_mask;
    logic [SAMPLE_BITS-1:0]   w_new_level;

    // offset classification
    logic signed [CMP_W-1:0]  w_offset;
    logic signed [CMP_W-1:0]  w_dz;
    logic signed [CMP_W-1:0]  w_th;
    logic                     w_in_deadzone;
    t_dir                     w_dir_raw;
    t_dir                     w_dir;

    // elapsed time checks
    logic [31:0]              w_dir_elapsed;
    logic [31:0]              w_btn_elapsed;
    logic                     w_dir_ok;
    logic                     w_btn_ok;

    // calibration mean
    logic [CAL_SUM_W-1:0]     w_cal_total;
    logic [PROD_W-1:0]        w_cal_prod;
    logic [SAMPLE_BITS-1:0]   w_cal_mean;
    logic                     w_cal_last;
    logic                     w_cal_good;

    always_comb begin
        // truncating divide by 2^shift: bias negative differences first
        w_diff      = $signed({1'b0, r_in_word.sample}) - $signed({1'b0, r_filtered_level});
        w_bias_mask = (8'd1 << r_filter_shift) - 8'd1;
        w_bias      = w_diff[DIFF_W-1] ? $signed(DIFF_W'(w_bias_mask)) : '0;
        w_step      = (w_diff + w_bias) >>> r_filter_shift;
        w_filt_sum  = $signed({1'b0, r_filtered_level}) + w_step;
        w_new_level = w_filt_sum[SAMPLE_BITS-1:0];

        w_offset = CMP_W'($signed({1'b0, w_new_level}) - $signed({1'b0, r_center_level}));
        w_dz     = $signed(CMP_W'(r_deadzone));
        w_th     = $signed(CMP_W'(r_threshold));

        w_in_deadzone = (w_offset < w_dz) && (w_offset > -w_dz);
        if (w_in_deadzone) begin
            w_dir_raw = DIR_NONE;
        end else if (w_offset > w_th) begin
            w_dir_raw = DIR_DOWN;
        end else if (w_offset < -w_th) begin
            w_dir_raw = DIR_UP;
        end else begin
            w_dir_raw = DIR_NONE;
        end

        case (w_dir_raw)
            DIR_UP:   w_dir = r_invert_axis ? DIR_DOWN : DIR_UP;
            DIR_DOWN: w_dir = r_invert_axis ? DIR_UP : DIR_DOWN;
            default:  w_dir = DIR_NONE;
        endcase

        // modulo 2^32 elapsed time
        w_dir_elapsed = r_in_word.now_ms - r_last_dir_time;
        w_btn_elapsed = r_in_word.now_ms - r_last_btn_time;
        w_dir_ok      = w_dir_elapsed >= {16'd0, r_repeat_interval};
        w_btn_ok      = w_btn_elapsed >= {16'd0, r_debounce_interval};

        // mean = total / CAL_SAMPLES by exact reciprocal multiply
        w_cal_total = r_cal_sum + CAL_SUM_W'(r_in_word.sample);
        w_cal_prod  = PROD_W'(w_cal_total) * PROD_W'(CAL_RECIP);
        w_cal_mean  = w_cal_prod[RECIP_SHIFT +: SAMPLE_BITS];
        w_cal_last  = (r_cal_count == CAL_LAST);
        w_cal_good  = (w_cal_mean > CAL_LOW) && (w_cal_mean < CAL_HIGH);

        // defaults: state held, empty result
        n_filtered_level = r_filtered_level;
        n_center_level   = r_center_level;
        n_last_dir_time  = r_last_dir_time;
        n_last_btn_time  = r_last_btn_time;
        n_button_state   = r_button_state;
        n_cal_sum        = r_cal_sum;
        n_cal_count      = r_cal_count;
        n_out_word       = '0;
        n_out_word.calibration_status = CAL_NONE;

        case (t_action'(r_in_word.action))
            ACT_CALIBRATE: begin
                if (w_cal_last) begin
                    n_cal_sum   = '0;
                    n_cal_count = '0;
                    if (w_cal_good) begin
                        n_center_level   = w_cal_mean;
                        n_filtered_level = w_cal_mean;
                        n_out_word.calibration_status = CAL_ACCEPTED;
                    end else begin
                        n_out_word.calibration_status = CAL_REJECTED;
                    end
                end else begin
                    n_cal_sum   = w_cal_total;
                    n_cal_count = r_cal_count + CAL_CNT_W'(1);
                end
            end
            default: begin
                n_filtered_level = w_new_level;
                if (w_dir != DIR_NONE && w_dir_ok) begin
                    n_last_dir_time       = r_in_word.now_ms;
                    n_out_word.up_event   = (w_dir == DIR_UP);
                    n_out_word.down_event = (w_dir == DIR_DOWN);
                end
                // releases update state but give no event
                if (r_in_word.button_pressed != r_button_state && w_btn_ok) begin
                    n_last_btn_time        = r_in_word.now_ms;
                    n_button_state         = r_in_word.button_pressed;
                    n_out_word.press_event = r_in_word.button_pressed;
                end
            end
        endcase
    end

    // state registers, updated once per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filtered_level <= MID_LEVEL;
            r_center_level   <= MID_LEVEL;
            r_last_dir_time  <= '0;
            r_last_btn_time  <= '0;
            r_button_state   <= 1'b0;
            r_cal_sum        <= '0;
            r_cal_count      <= '0;
        end else if (w_adv) begin
            r_filtered_level <= n_filtered_level;
            r_center_level   <= n_center_level;
            r_last_dir_time  <= n_last_dir_time;
            r_last_btn_time  <= n_last_btn_time;
            r_button_state   <= n_button_state;
            r_cal_sum        <= n_cal_sum;
            r_cal_count      <= n_cal_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_word <= i_in_word;
        end
        if (w_adv) begin
            r_out_word <= n_out_word;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.up_event && o_out_word.down_event))
        else $error("up and down pulse in one word");

    a_cal_no_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_word.action) |=>
            (!r_out_word.up_event && !r_out_word.down_event && !r_out_word.press_event))
        else $error("calibration word produced an event");

    a_poll_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_in_word.action) |=> (r_out_word.calibration_status == CAL_NONE))
        else $error("poll word produced a calibration status");

    a_press_sets_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_out_word.press_event) |=> r_button_state)
        else $error("press event without button state set");

    a_cal_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_out_word.calibration_status == CAL_ACCEPTED) |=>
            (r_center_level == r_filtered_level && r_cal_count == '0 && r_cal_sum == '0))
        else $error("accepted calibration did not load center and filter");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for joystick_axis_direction_qualifier_core: poll and
// calibration words go in through the stall handshake with random gaps, a
// scoreboard predicts every result word and checks it field by field
// ----------------------------------------------------------------------------
module tb
    import jadq_pkg::*;
;

    // block constants as this bench understands them
    localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
    localparam int MID_POINT     = 1 << (SAMPLE_BITS - 1);
    localparam int CAL_SET       = 16;
    localparam int CAL_MEAN_LOW  = 50;
    localparam int CAL_MEAN_HIGH = SAMPLE_MAX - 50;

    // run shape
    localparam int PHASES          = 9;
    localparam int WORDS_PER_PHASE = 60;
    localparam int HOLD_PHASE      = 4;
    localparam int UNMAPPED_PHASE  = 5;
    localparam int CALM_PHASE      = 6;
    localparam int RX_HOLD_CYCLES  = 80;
    localparam int SETTLE_CYCLES   = 4;
    localparam int IDLE_LIMIT      = 2000;
    localparam int REG_SLOTS       = (1 << PADDR_W) / 4;
    localparam int MAX_REPORTS     = 60;

    // ------------------------------------------------------------------------
    // scoreboard: keeps its own copy of the registers and the axis state,
    // works out the result of each accepted word and queues it
    // ------------------------------------------------------------------------
    class axis_event_scoreboard;
        logic [11:0] dz;
        logic [11:0] th;
        logic [15:0] rep_interval;
        logic [15:0] debounce_ms;
        logic [2:0]  shift;
        logic        inv;
        int          filt;
        int          ctr;
        logic [31:0] last_dir_at;
        logic [31:0] last_btn_ms;
        logic        btn;
        int          cal_sum;
        int          cal_cnt;
        t_out_word   expected_words[$];
        int          errors;
        int          seen;

        function new();
            dz           = 12'd250;
            th           = 12'd700;
            rep_interval = 16'd180;
            debounce_ms  = 16'd120;
            shift        = 3'd2;
            inv          = 1'b0;
            filt         = MID_POINT;
            ctr          = MID_POINT;
            last_dir_at  = '0;
            last_btn_ms  = '0;
            btn          = 1'b0;
            cal_sum      = 0;
            cal_cnt      = 0;
            errors       = 0;
            seen         = 0;
        endfunction

        function void write_reg(int idx, logic [31:0] v);
            case (idx)
                REG_DEADZONE:          dz = v[11:0];
                REG_THRESHOLD:         th = v[11:0];
                REG_REPEAT_INTERVAL:   rep_interval = v[15:0];
                REG_DEBOUNCE_INTERVAL: debounce_ms = v[15:0];
                REG_FILTER_SHIFT:      shift = v[2:0];
                REG_INVERT_AXIS:       inv = v[0];
                default: ;
            endcase
        endfunction

        function t_dir classify(int y);
            t_dir d;
            d = DIR_NONE;
            // inside the deadzone nothing is reported at all
            if (y < int'(dz) && y > -int'(dz))
                return DIR_NONE;
            if (y > int'(th))
                d = DIR_DOWN;
            else if (y < -int'(th))
                d = DIR_UP;
            if (d != DIR_NONE && inv) begin
                if (d == DIR_UP)
                    d = DIR_DOWN;
                else
                    d = DIR_UP;
            end
            return d;
        endfunction

        function t_out_word qualify_word(t_in_word w);
            t_out_word   r;
            int          stp;
            int          y;
            int          mean;
            t_dir        d;
            logic [31:0] dir_age;
            logic [31:0] btn_age;
            r = '0;
            if (w.action == ACT_CALIBRATE) begin
                cal_sum += int'(w.sample);
                cal_cnt++;
                if (cal_cnt >= CAL_SET) begin
                    mean = cal_sum / CAL_SET;
                    if (mean > CAL_MEAN_LOW && mean < CAL_MEAN_HIGH) begin
                        ctr  = mean;
                        filt = mean;
                        r.calibration_status = CAL_ACCEPTED;
                    end else begin
                        r.calibration_status = CAL_REJECTED;
                    end
                    cal_sum = 0;
                    cal_cnt = 0;
                end
            end else begin
                // signed division truncates toward zero
                stp  = (int'(w.sample) - filt) / (1 << shift);
                filt = (filt + stp) & SAMPLE_MAX;
                y    = filt - ctr;
                d    = classify(y);
                // elapsed times wrap modulo 2^32
                dir_age = w.now_ms - last_dir_at;
                if (d != DIR_NONE && dir_age >= 32'(rep_interval)) begin
                    last_dir_at  = w.now_ms;
                    r.up_event   = (d == DIR_UP);
                    r.down_event = (d == DIR_DOWN);
                end
                btn_age = w.now_ms - last_btn_ms;
                if (w.button_pressed != btn && btn_age >= 32'(debounce_ms)) begin
                    last_btn_ms   = w.now_ms;
                    btn           = w.button_pressed;
                    r.press_event = w.button_pressed;
                end
            end
            return r;
        endfunction

        function void note_input_word(t_in_word w);
            expected_words.push_back(qualify_word(w));
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("ERROR: %s", msg);
        endtask

        task check_result_word(t_out_word got);
            t_out_word want;
            seen++;
            if (expected_words.size() == 0) begin
                report($sformatf("result %0d (%b) arrived with no word outstanding", seen, got));
                return;
            end
            want = expected_words.pop_front();
            if (got.up_event !== want.up_event || got.down_event !== want.down_event ||
                    got.press_event !== want.press_event ||
                    got.calibration_status !== want.calibration_status)
                report($sformatf("result %0d: up %b/%b down %b/%b press %b/%b cal %0d/%0d",
                    seen, got.up_event, want.up_event, got.down_event, want.down_event,
                    got.press_event, want.press_event, got.calibration_status,
                    want.calibration_status));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_word           i_in_word;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_word          o_out_word;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    axis_event_scoreboard sb;
    bit                   rx_hold_req = 1'b0;  // asks the receiver for one long hold
    bit                   calm = 1'b0;         // no gaps on either side
    int                   words_sent = 0;
    logic [31:0]          wall_ms;

    wire in_fire  = i_in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !i_out_stall;

    joystick_axis_direction_qualifier_core #(
        .CAL_SAMPLES(CAL_SET)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int clamp_level(int v);
        if (v < 0)
            return 0;
        if (v > SAMPLE_MAX)
            return SAMPLE_MAX;
        return v;
    endfunction

    // both handshakes are sampled at the rising edge, before the block updates
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire)
                sb.note_input_word(i_in_word);
            if (out_fire)
                sb.check_result_word(o_out_word);
        end
    end

    // receiver side: random stall, one long hold when asked
    initial begin : rx_stall
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                // hold counted here while the sender keeps offering words
                i_out_stall = 1'b1;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                i_out_stall = 1'b0;
                rx_hold_req = 1'b0;
            end else if (!calm) begin
                n = pick_gap();
                if (n > 0) begin
                    i_out_stall = 1'b1;
                    repeat (n) @(negedge i_clk);
                    i_out_stall = 1'b0;
                end
            end
        end
    end

    // ends the run when neither channel moves for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (in_fire || out_fire)
                idle = 0;
            else
                idle++;
        end
        $display("joystick_axis_direction_qualifier_core test failed");
        $finish;
    end

    // offers one word and returns at a falling edge once it was taken;
    // valid stays high for a back-to-back word
    task send_word(t_action act, int smp, logic btn, logic [31:0] t);
        int gap;
        i_in_word.action         = act;
        i_in_word.sample         = SAMPLE_BITS'(smp);
        i_in_word.button_pressed = btn;
        i_in_word.now_ms         = t;
        i_in_valid               = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        words_sent++;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // wait until every result is back, then let the pipe settle
    task drain_results();
        i_in_valid = 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // setup cycle then access cycle, register written at the access edge
    task apb_write(int idx, logic [31:0] v);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = PADDR_W'(4 * idx);
        pwdata  = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        sb.write_reg(idx, v);
    endtask

    task configure(int p);
        logic [11:0] dz;
        logic [11:0] th;
        logic [15:0] rep;
        logic [15:0] deb;
        logic [2:0]  sh;
        logic        inv;
        int          i;
        case (p)
            1: begin
                // everything at its floor, inverted axis
                dz = '0; th = '0; rep = '0; deb = '0; sh = '0; inv = 1'b1;
            end
            2: begin
                // everything at its ceiling, filter shift of seven
                dz = '1; th = '1; rep = '1; deb = '1; sh = '1; inv = 1'b0;
            end
            3: begin
                // deadzone above threshold
                dz  = 12'd900;
                th  = 12'd300;
                rep = 16'($urandom_range(0, 400));
                deb = 16'($urandom_range(0, 300));
                sh  = 3'd1;
                inv = 1'b1;
            end
            default: begin
                dz  = 12'($urandom_range(0, 1000));
                th  = 12'($urandom_range(0, 1500));
                rep = 16'($urandom_range(0, 500));
                deb = 16'($urandom_range(0, 400));
                sh  = 3'($urandom_range(0, 7));
                inv = 1'($urandom_range(0, 1));
            end
        endcase
        apb_write(REG_DEADZONE, 32'(dz));
        apb_write(REG_THRESHOLD, 32'(th));
        apb_write(REG_REPEAT_INTERVAL, 32'(rep));
        apb_write(REG_DEBOUNCE_INTERVAL, 32'(deb));
        apb_write(REG_FILTER_SHIFT, 32'(sh));
        apb_write(REG_INVERT_AXIS, 32'(inv));
        // unmapped addresses must leave every register alone
        if (p == UNMAPPED_PHASE) begin
            for (i = int'(REG_INVERT_AXIS) + 1; i < REG_SLOTS; i++)
                apb_write(i, $urandom());
        end
    endtask

    task run_phase(int n);
        int   stop_at;
        int   kind;
        int   target;
        int   mean;
        int   lim;
        int   extra;
        int   d;
        int   i;
        int   r;
        logic btn_level;
        stop_at   = words_sent + n;
        btn_level = 1'b0;
        while (words_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                // poll burst pulling the filter toward one level
                case ($urandom_range(0, 5))
                    0: target = 0;
                    1: target = SAMPLE_MAX;
                    2: target = sb.ctr + int'(sb.th) + int'($urandom_range(1, 300));
                    3: target = sb.ctr - int'(sb.th) - int'($urandom_range(1, 300));
                    default: target = $urandom_range(0, SAMPLE_MAX);
                endcase
                repeat ($urandom_range(4, 14)) begin
                    r = $urandom_range(0, 99);
                    if (r >= 95)
                        wall_ms = $urandom();   // jump anywhere, backwards too
                    else if (r >= 85)
                        wall_ms += $urandom_range(400, 70000);
                    else if (r >= 50)
                        wall_ms += $urandom_range(60, 400);
                    else if (r >= 8)
                        wall_ms += $urandom_range(1, 60);
                    // contact bounce
                    if ($urandom_range(0, 3) == 0)
                        btn_level = ~btn_level;
                    send_word(ACT_POLL, clamp_level(target + int'($urandom_range(0, 80)) - 40),
                        btn_level, wall_ms);
                end
            end else if (kind < 75) begin
                // close any open set so the chosen mean lands on a whole set
                while (sb.cal_cnt != 0)
                    send_word(ACT_CALIBRATE, $urandom_range(0, SAMPLE_MAX),
                        1'($urandom_range(0, 1)), wall_ms);
                case ($urandom_range(0, 9))
                    0: mean = CAL_MEAN_LOW;
                    1: mean = CAL_MEAN_LOW + 1;
                    2: mean = CAL_MEAN_HIGH - 1;
                    3: mean = CAL_MEAN_HIGH;
                    4: mean = 0;
                    5: mean = SAMPLE_MAX;
                    default: mean = $urandom_range(0, SAMPLE_MAX);
                endcase
                lim = (mean < SAMPLE_MAX - mean) ? mean : SAMPLE_MAX - mean;
                if (lim > 400)
                    lim = 400;
                extra = $urandom_range(0, CAL_SET - 1);
                // pairs around the mean, plus a remainder that the floor drops
                for (i = 0; i < CAL_SET; i += 2) begin
                    d = $urandom_range(0, lim);
                    if (i == CAL_SET - 2 && mean + d + extra <= SAMPLE_MAX)
                        d = d + extra;
                    send_word(ACT_CALIBRATE, mean + d, 1'($urandom_range(0, 1)), wall_ms);
                    send_word(ACT_CALIBRATE, mean - (i == CAL_SET - 2 && d > lim ? d - extra : d),
                        1'($urandom_range(0, 1)), wall_ms);
                    // a poll inside a set keeps the running sum
                    if ($urandom_range(0, 9) == 0) begin
                        wall_ms += $urandom_range(1, 200);
                        send_word(ACT_POLL, $urandom_range(0, SAMPLE_MAX), btn_level, wall_ms);
                    end
                end
            end else if (kind < 85) begin
                // set broken off part way
                repeat ($urandom_range(1, CAL_SET - 1))
                    send_word(ACT_CALIBRATE, $urandom_range(0, SAMPLE_MAX),
                        1'($urandom_range(0, 1)), wall_ms);
            end else begin
                // unrelated words, any time stamp
                repeat ($urandom_range(1, 4))
                    send_word(t_action'($urandom_range(0, 1)), $urandom_range(0, SAMPLE_MAX),
                        1'($urandom_range(0, 1)), $urandom());
            end
        end
    endtask

    initial begin : stimulus
        int p;
        int i;
        sb         = new();
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed words under reset settings
        send_word(ACT_POLL, SAMPLE_MAX, 1'b1, 32'd1000);     // press, offset inside band
        send_word(ACT_POLL, SAMPLE_MAX, 1'b1, 32'd1010);     // first down pulse
        send_word(ACT_POLL, SAMPLE_MAX, 1'b0, 32'd1050);     // too soon: no repeat, bounce
        send_word(ACT_POLL, SAMPLE_MAX, 1'b0, 32'd1200);     // repeat pulse, release taken
        send_word(ACT_POLL, 0, 1'b0, 32'd1300);
        send_word(ACT_POLL, 0, 1'b0, 32'd1600);              // back inside the deadzone: no pulse
        send_word(ACT_POLL, MID_POINT, 1'b1, 32'hFFFF_FFF0); // time near the wrap
        send_word(ACT_POLL, MID_POINT, 1'b0, 32'd5);         // short elapsed across wrap
        send_word(ACT_POLL, SAMPLE_MAX, 1'b1, 32'd3);        // backwards: long elapsed
        // one calibration set from both extremes, a poll in the middle
        for (i = 0; i < CAL_SET; i++) begin
            if (i == CAL_SET / 2)
                send_word(ACT_POLL, MID_POINT, 1'b0, 32'd10);
            send_word(ACT_CALIBRATE, (i == CAL_SET - 1) ? SAMPLE_MAX : 0, 1'b1, 32'd12);
        end
        wall_ms = 32'd100;

        for (p = 1; p <= PHASES; p++) begin
            drain_results();
            configure(p);
            calm = (p == CALM_PHASE);
            if (p == HOLD_PHASE)
                rx_hold_req = 1'b1;
            run_phase(WORDS_PER_PHASE);
        end
        drain_results();

        if (sb.errors == 0)
            $display("joystick_axis_direction_qualifier_core test passed");
        else
            $display("joystick_axis_direction_qualifier_core test failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/jadq_pkg.sv
rtl/joystick_axis_direction_qualifier_core.sv
dv/tb.sv
